>>> sv/deq_pkg.sv
// shared types, constants and codes for the double-ended queue
`default_nettype none
package deq_pkg;

   localparam int DEPTH   = 1024;
   localparam int ADDR_W  = $clog2(DEPTH);
   localparam int COUNT_W = $clog2(DEPTH + 1);
   localparam int DATA_W  = 32;

   localparam logic [ADDR_W-1:0]  LAST_SLOT = ADDR_W'(DEPTH - 1);
   localparam logic [COUNT_W-1:0] FULL_COUNT = COUNT_W'(DEPTH);

   typedef enum logic [2:0] {
      OP_PUSH_FRONT = 3'd0,
      OP_PUSH_BACK  = 3'd1,
      OP_POP_FRONT  = 3'd2,
      OP_POP_BACK   = 3'd3,
      OP_PEEK_FRONT = 3'd4,
      OP_PEEK_BACK  = 3'd5,
      OP_SIZE       = 3'd6,
      OP_CLEAR      = 3'd7
   } opcode_type;

   typedef enum logic [1:0] {
      ST_OK    = 2'd0,
      ST_VALUE = 2'd1,
      ST_EMPTY = 2'd2,
      ST_FULL  = 2'd3
   } status_type;

   typedef struct packed {
      opcode_type               opcode;
      logic signed [DATA_W-1:0] operand_value;
   } req_type;

   typedef struct packed {
      status_type               status;
      logic signed [DATA_W-1:0] result_value;
      logic [COUNT_W-1:0]       fill_level;
   } rsp_type;

   typedef struct packed {
      logic              wr_en;
      logic              rd_en;
      logic [ADDR_W-1:0] addr;
      logic [DATA_W-1:0] wr_data;
   } ram_cmd_type;

endpackage
`default_nettype wire

>>> sv/deq_ram.sv
// slot storage: single-port synchronous ram with registered read data
`default_nettype none
module deq_ram (
   input  wire logic                          clock,
   input  wire deq_pkg::ram_cmd_type          cmd,
   output logic [deq_pkg::DATA_W-1:0]         rd_data
);
   import deq_pkg::*;

   logic [DATA_W-1:0] slots_mem [DEPTH];
   logic [DATA_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (cmd.wr_en) begin
         slots_mem[cmd.addr] <= cmd.wr_data;
      end
      if (cmd.rd_en) begin
         rd_data_ff <= slots_mem[cmd.addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

>>> sv/deq_ctrl.sv
// pointer and count control, ram command generation and result register
`default_nettype none
module deq_ctrl (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       accept,
   input  wire deq_pkg::req_type           req,
   input  wire logic [deq_pkg::DATA_W-1:0] rd_data,
   output deq_pkg::ram_cmd_type            cmd,
   output logic                            rsp_valid,
   output deq_pkg::rsp_type                rsp
);
   import deq_pkg::*;

   logic [ADDR_W-1:0]  front_ff, front_in;
   logic [COUNT_W-1:0] count_ff, count_in;
   logic               valid_ff, valid_in;
   logic               use_rd_ff, use_rd_in;
   status_type         status_ff, status_in;

   logic               is_empty, is_full;
   logic [ADDR_W:0]    back_sum;
   logic [ADDR_W-1:0]  tail_slot, last_slot, front_dec, front_inc;

   // slot just past the back, and slot of the back entry
   always_comb begin
      back_sum  = {1'b0, front_ff} + (ADDR_W+1)'(count_ff);
      tail_slot = (back_sum >= (ADDR_W+1)'(DEPTH)) ?
                  ADDR_W'(back_sum - (ADDR_W+1)'(DEPTH)) : back_sum[ADDR_W-1:0];
      last_slot = (tail_slot == '0) ? LAST_SLOT : tail_slot - 1'b1;
      front_dec = (front_ff == '0) ? LAST_SLOT : front_ff - 1'b1;
      front_inc = (front_ff == LAST_SLOT) ? '0 : front_ff + 1'b1;
   end

   assign is_empty = (count_ff == '0);
   assign is_full  = (count_ff == FULL_COUNT);

   always_comb begin
      front_in  = front_ff;
      count_in  = count_ff;
      valid_in  = accept;
      use_rd_in = 1'b0;
      status_in = ST_OK;
      cmd       = '0;
      cmd.wr_data = req.operand_value;
      if (accept) begin
         case (req.opcode)
            OP_PUSH_FRONT, OP_PUSH_BACK: begin
               if (is_full) begin
                  status_in = ST_FULL;
               end else begin
                  cmd.wr_en = 1'b1;
                  count_in  = count_ff + 1'b1;
                  if (req.opcode == OP_PUSH_FRONT) begin
                     cmd.addr = front_dec;
                     front_in = front_dec;
                  end else begin
                     cmd.addr = tail_slot;
                  end
               end
            end
            OP_POP_FRONT, OP_PEEK_FRONT, OP_POP_BACK, OP_PEEK_BACK: begin
               if (is_empty) begin
                  status_in = ST_EMPTY;
               end else begin
                  status_in = ST_VALUE;
                  use_rd_in = 1'b1;
                  cmd.rd_en = 1'b1;
                  if (req.opcode == OP_POP_FRONT || req.opcode == OP_PEEK_FRONT) begin
                     cmd.addr = front_ff;
                  end else begin
                     cmd.addr = last_slot;
                  end
                  if (req.opcode == OP_POP_FRONT) begin
                     front_in = front_inc;
                     count_in = count_ff - 1'b1;
                  end
                  if (req.opcode == OP_POP_BACK) begin
                     count_in = count_ff - 1'b1;
                  end
               end
            end
            OP_CLEAR: begin
               front_in = '0;
               count_in = '0;
            end
            default: begin
               // size query only reports the count
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         front_ff <= '0;
         count_ff <= '0;
         valid_ff <= 1'b0;
      end else begin
         front_ff <= front_in;
         count_ff <= count_in;
         valid_ff <= valid_in;
      end
      use_rd_ff <= use_rd_in;
      status_ff <= status_in;
   end

   // read data lands together with the result strobe
   assign rsp_valid         = valid_ff;
   assign rsp.status        = status_ff;
   assign rsp.result_value  = use_rd_ff ? signed'(rd_data) : '0;
   assign rsp.fill_level    = count_ff;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= FULL_COUNT)
      else $error("fill count beyond depth");

   a_rsp_follows: assert property (@(posedge clock) disable iff (reset)
      accept |=> rsp_valid)
      else $error("transaction without result");

   a_empty_level: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp.status == ST_EMPTY) |-> rsp.fill_level == '0)
      else $error("empty error with nonzero fill level");

   a_full_level: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp.status == ST_FULL) |-> rsp.fill_level == FULL_COUNT)
      else $error("full error with queue not full");

   a_count_step: assert property (@(posedge clock) disable iff (reset)
      !accept |=> count_ff == $past(count_ff))
      else $error("fill count moved without a transaction");

endmodule
`default_nettype wire

>>> sv/double_ended_queue.sv
// double-ended queue of signed 32-bit values on a ram ring buffer
//
//   channel   ports                          handshake
//   request   start, busy, req_data          taken when start && !busy
//   response  rsp_valid, rsp_data            one-cycle strobe, no back-pressure
//
// each transaction gives its result in the cycle after it is taken, since the
// read data of the single slot port is registered. a new transaction may be
// taken every cycle; busy stays low, the ring pointers update at acceptance so
// overlapping slot accesses are already ordered by the ram port.
// reset clears the pointers, fill count and result strobe; slots are not cleared.
`default_nettype none
module double_ended_queue (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              start,
   output logic                   busy,
   input  wire deq_pkg::req_type  req_data,
   output logic                   rsp_valid,
   output deq_pkg::rsp_type       rsp_data
);
   import deq_pkg::*;

   ram_cmd_type       ram_cmd;
   logic [DATA_W-1:0] ram_rd_data;
   logic              accept;

   assign busy   = 1'b0;
   assign accept = start && !busy;

   deq_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .accept    (accept),
      .req       (req_data),
      .rd_data   (ram_rd_data),
      .cmd       (ram_cmd),
      .rsp_valid (rsp_valid),
      .rsp       (rsp_data)
   );

   deq_ram u_ram (
      .clock   (clock),
      .cmd     (ram_cmd),
      .rd_data (ram_rd_data)
   );

endmodule
`default_nettype wire
